@@ rtl/cudw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cudw_pkg
// Shared types, constants and the Cyrillic font table of the display writer.
// ----------------------------------------------------------------------------
package cudw_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] LEAD_UPPER    = 8'hD0;
   localparam logic [7:0] LEAD_LOWER    = 8'hD1;
   localparam logic [7:0] UPPER_BASE    = 8'h90;
   localparam logic [7:0] UPPER_TOP     = 8'hBF;
   localparam logic [7:0] LOWER_OFFSET  = 8'h30;
   localparam logic [7:0] LOWER_BASE    = 8'h80;
   localparam logic [7:0] LOWER_TOP     = 8'h8F;
   localparam logic [7:0] UPPER_YO_CODE = 8'hA2;
   localparam logic [7:0] UPPER_YO_BYTE = 8'h81;
   localparam logic [7:0] LOWER_YO_CODE = 8'hB5;
   localparam logic [7:0] LOWER_YO_BYTE = 8'h91;

   localparam logic REG_NARROW_BUS  = 1'b0;
   localparam logic REG_REPLACEMENT = 1'b1;

   localparam logic [7:0] REPLACEMENT_RESET = 8'd63;

   typedef struct packed {
      logic [7:0] code;
      logic       rs;
      logic       bad;
   } write_type;

   function automatic logic [7:0] font_lookup(input logic [5:0] idx);
      logic [7:0] code;
      case (idx)
         6'd0:  code = 8'h41;  6'd1:  code = 8'hA0;  6'd2:  code = 8'h42;
         6'd3:  code = 8'hA1;  6'd4:  code = 8'hE0;  6'd5:  code = 8'h45;
         6'd6:  code = 8'hA3;  6'd7:  code = 8'hA4;  6'd8:  code = 8'hA5;
         6'd9:  code = 8'hA6;  6'd10: code = 8'h4B;  6'd11: code = 8'hA7;
         6'd12: code = 8'h4D;  6'd13: code = 8'h48;  6'd14: code = 8'h4F;
         6'd15: code = 8'hA8;  6'd16: code = 8'h50;  6'd17: code = 8'h43;
         6'd18: code = 8'h54;  6'd19: code = 8'hA9;  6'd20: code = 8'hAA;
         6'd21: code = 8'h58;  6'd22: code = 8'hE1;  6'd23: code = 8'hAB;
         6'd24: code = 8'hAC;  6'd25: code = 8'hE2;  6'd26: code = 8'hAD;
         6'd27: code = 8'hAE;  6'd28: code = 8'hC4;  6'd29: code = 8'hAF;
         6'd30: code = 8'hB0;  6'd31: code = 8'hB1;  6'd32: code = 8'h61;
         6'd33: code = 8'hB2;  6'd34: code = 8'hB3;  6'd35: code = 8'hB4;
         6'd36: code = 8'hE3;  6'd37: code = 8'h65;  6'd38: code = 8'hB6;
         6'd39: code = 8'hB7;  6'd40: code = 8'hB8;  6'd41: code = 8'hB9;
         6'd42: code = 8'hBA;  6'd43: code = 8'hBB;  6'd44: code = 8'hBC;
         6'd45: code = 8'hBD;  6'd46: code = 8'h6F;  6'd47: code = 8'hBE;
         6'd48: code = 8'h70;  6'd49: code = 8'h63;  6'd50: code = 8'hBF;
         6'd51: code = 8'h79;  6'd52: code = 8'hE4;  6'd53: code = 8'h78;
         6'd54: code = 8'hE5;  6'd55: code = 8'hC0;  6'd56: code = 8'hC1;
         6'd57: code = 8'hE6;  6'd58: code = 8'hC2;  6'd59: code = 8'hC3;
         6'd60: code = 8'hC4;  6'd61: code = 8'hC5;  6'd62: code = 8'hC6;
         6'd63: code = 8'hC7;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

@@ rtl/cyrillic_utf8_char_display_writer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cyrillic_utf8_char_display_writer
// Turns UTF-8 Cyrillic text bytes and raw command bytes into character
// display bus strobes.
//
// req_ channel: one item per byte; tuser is the action (1 = command byte),
// tlast ends a string and drops a pending lead byte. A lead byte 0xD0/0xD1
// yields no strobe; the following text byte yields one mapped data write.
// rsp_ channel: one strobe per write on an 8-bit bus, two on a 4-bit bus
// (high nibble, then low nibble); tlast marks the final strobe of a write.
// The write of an accepted item is registered in the two-entry queue, which
// parts the front from the strobe sequencer, then in the output register.
// One item per cycle on an 8-bit bus unless the receiver stalls; a 4-bit bus
// holds the single output strobe register for both nibbles of a write. When
// the receiver stalls, the queue fills and req_tready falls. Reset clears the
// pending lead and the queue, and sets narrow_bus to 0 and replacement_code to
// 63. Write registers over csr_ only while idle; the block does not check it.
// ----------------------------------------------------------------------------
module cyrillic_utf8_char_display_writer #(
   parameter int QUEUE_DEPTH = cudw_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] action
   input  wire logic        req_tlast,   // string_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] bus_value
   output logic [1:0]       rsp_tuser,   // [0] register_select, [1] bad_sequence
   output logic             rsp_tlast,   // last_of_write
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic                narrow_ff, narrow_in;
   logic [7:0]          repl_ff, repl_in;
   logic                csr_write;
   logic                push, pop, full, empty;
   cudw_pkg::write_type push_write;
   cudw_pkg::write_type head;
   logic                out_rs, out_bad;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      narrow_in = narrow_ff;
      repl_in   = repl_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            cudw_pkg::REG_NARROW_BUS:  narrow_in = csr_pwdata[0];
            cudw_pkg::REG_REPLACEMENT: repl_in   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         cudw_pkg::REG_NARROW_BUS:  csr_prdata = {31'd0, narrow_ff};
         cudw_pkg::REG_REPLACEMENT: csr_prdata = {24'd0, repl_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         narrow_ff <= 1'b0;
         repl_ff   <= cudw_pkg::REPLACEMENT_RESET;
      end else begin
         narrow_ff <= narrow_in;
         repl_ff   <= repl_in;
      end
   end

   cudw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .in_action        (req_tuser),
      .in_byte          (req_tdata),
      .in_end           (req_tlast),
      .replacement_code (repl_ff),
      .push             (push),
      .push_write       (push_write),
      .queue_full       (full)
   );

   cudw_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_write (push_write),
      .full       (full),
      .pop        (pop),
      .head       (head),
      .empty      (empty)
   );

   cudw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .narrow_bus (narrow_ff),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_value  (rsp_tdata),
      .out_rs     (out_rs),
      .out_last   (rsp_tlast),
      .out_bad    (out_bad)
   );

   assign rsp_tuser = {out_bad, out_rs};

endmodule
`default_nettype wire

@@ rtl/cudw_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cudw_front
// Accepts items, tracks a pending lead byte and turns each item into zero
// or one display write for the queue.
// ----------------------------------------------------------------------------
module cudw_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic                in_action,
   input  wire logic [7:0]          in_byte,
   input  wire logic                in_end,
   input  wire logic [7:0]          replacement_code,
   output logic                     push,
   output cudw_pkg::write_type      push_write,
   input  wire logic                queue_full
);

   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_UPPER = 2'd1;
   localparam logic [1:0] PEND_LOWER = 2'd2;

   logic [1:0] pend_ff;
   logic [1:0] pend_in;
   logic       accept;
   logic [5:0] upper_idx;
   logic [5:0] lower_idx;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   assign upper_idx = 6'(in_byte - cudw_pkg::UPPER_BASE);
   assign lower_idx = 6'(cudw_pkg::LOWER_OFFSET + (in_byte - cudw_pkg::LOWER_BASE));

   always_comb begin
      pend_in    = pend_ff;
      push       = 1'b0;
      push_write = '{code: in_byte, rs: 1'b1, bad: 1'b0};
      if (accept) begin
         if (in_action) begin
            push       = 1'b1;
            push_write = '{code: in_byte, rs: 1'b0, bad: 1'b0};
         end else if (pend_ff == PEND_UPPER) begin
            push       = 1'b1;
            pend_in    = PEND_NONE;
            push_write = '{code: replacement_code, rs: 1'b1, bad: 1'b1};
            if (in_byte == cudw_pkg::UPPER_YO_BYTE) begin
               push_write = '{code: cudw_pkg::UPPER_YO_CODE, rs: 1'b1, bad: 1'b0};
            end else if (in_byte >= cudw_pkg::UPPER_BASE && in_byte <= cudw_pkg::UPPER_TOP) begin
               push_write = '{code: cudw_pkg::font_lookup(upper_idx), rs: 1'b1, bad: 1'b0};
            end
         end else if (pend_ff == PEND_LOWER) begin
            push       = 1'b1;
            pend_in    = PEND_NONE;
            push_write = '{code: replacement_code, rs: 1'b1, bad: 1'b1};
            if (in_byte == cudw_pkg::LOWER_YO_BYTE) begin
               push_write = '{code: cudw_pkg::LOWER_YO_CODE, rs: 1'b1, bad: 1'b0};
            end else if (in_byte >= cudw_pkg::LOWER_BASE && in_byte <= cudw_pkg::LOWER_TOP) begin
               push_write = '{code: cudw_pkg::font_lookup(lower_idx), rs: 1'b1, bad: 1'b0};
            end
         end else if (in_byte == cudw_pkg::LEAD_UPPER) begin
            pend_in = PEND_UPPER;
         end else if (in_byte == cudw_pkg::LEAD_LOWER) begin
            pend_in = PEND_LOWER;
         end else begin
            push    = 1'b1;
            pend_in = PEND_NONE;
         end
         if (in_end) begin
            pend_in = PEND_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PEND_NONE;
      end else begin
         pend_ff <= pend_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/cudw_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cudw_queue
// Small first-in first-out buffer of display writes between front and back.
// ----------------------------------------------------------------------------
module cudw_queue #(
   parameter int QUEUE_DEPTH = cudw_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire cudw_pkg::write_type push_write,
   output logic                     full,
   input  wire logic                pop,
   output cudw_pkg::write_type      head,
   output logic                     empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   cudw_pkg::write_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_write;
      end
   end

endmodule
`default_nettype wire

@@ rtl/cudw_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cudw_back
// Takes display writes from the queue and sends them as bus strobes: one
// full byte, or high nibble then low nibble on a narrow bus.
// ----------------------------------------------------------------------------
module cudw_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                narrow_bus,
   input  wire cudw_pkg::write_type head,
   input  wire logic                empty,
   output logic                     pop,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [7:0]               out_value,
   output logic                     out_rs,
   output logic                     out_last,
   output logic                     out_bad
);

   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;
   logic [7:0] value_ff, value_in;
   logic       rs_ff, rs_in;
   logic       last_ff, last_in;
   logic       bad_ff, bad_in;
   logic       load;

   assign load = !empty && (!valid_ff || out_ready);

   always_comb begin
      valid_in = valid_ff && !out_ready;
      phase_in = phase_ff;
      value_in = value_ff;
      rs_in    = rs_ff;
      last_in  = last_ff;
      bad_in   = bad_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         rs_in    = head.rs;
         bad_in   = head.bad;
         if (narrow_bus && !phase_ff) begin
            value_in = {4'h0, head.code[7:4]};
            last_in  = 1'b0;
            phase_in = 1'b1;
         end else begin
            value_in = narrow_bus ? {4'h0, head.code[3:0]} : head.code;
            last_in  = 1'b1;
            phase_in = 1'b0;
            pop      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rs_ff    <= rs_in;
      last_ff  <= last_in;
      bad_ff   <= bad_in;
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_rs    = rs_ff;
   assign out_last  = last_ff;
   assign out_bad   = bad_ff;

endmodule
`default_nettype wire

@@ tb/cyrillic_utf8_char_display_writer_tb.sv @@
// ----------------------------------------------------------------------------
// cyrillic_utf8_char_display_writer_tb
// Self-checking bench for the Cyrillic UTF-8 display writer. A queue-fed
// driver sends text and command bytes with random gaps. A monitor with random
// stalls checks every display strobe against a predictor of the transcoding
// that is kept in step at each accepted item. Bus width and replacement code
// are reprogrammed over the CSR port between drained phases.
// ----------------------------------------------------------------------------
module cyrillic_utf8_char_display_writer_tb;

   localparam logic ACT_TEXT = 1'b0;
   localparam logic ACT_CMD  = 1'b1;
   localparam int   WATCHDOG_LIMIT = 1000;
   localparam int   PHASES = 8;
   localparam int   ITEMS_PER_PHASE = 165;

   // glyph codes, entry 0 in the top byte
   localparam logic [511:0] GLYPHS = {
      64'h41a042a1e045a3a4, 64'ha5a64ba74d484fa8,
      64'h504354a9aa58e1ab, 64'hace2adaec4afb0b1,
      64'h61b2b3b4e365b6b7, 64'hb8b9babbbcbd6fbe,
      64'h7063bf79e478e5c0, 64'hc1e6c2c3c4c5c6c7};

   typedef enum logic [1:0] {HELD_NONE, HELD_UPPER, HELD_LOWER} held_lead_type;

   typedef struct {
      logic       action;
      logic [7:0] data;
      logic       last;
      int         gap;
   } text_item_type;

   typedef struct {
      logic [7:0] bus;
      logic       rs;
      logic       last;
      logic       bad;
   } strobe_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tuser = 1'b0;   // [0] action
   logic        req_tlast = 1'b0;   // string_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [7:0] bus_value
   logic [1:0]  rsp_tuser;          // [0] register_select, [1] bad_sequence
   logic        rsp_tlast;          // last_of_write
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   text_item_type text_queue[$];
   strobe_type    strobes_due[$];
   text_item_type on_bus;
   held_lead_type held = HELD_NONE;
   logic        cfg_narrow = 1'b0;
   logic [7:0]  cfg_replacement = cudw_pkg::REPLACEMENT_RESET;
   logic        src_pace = 1'b1;
   logic        sink_pace = 1'b1;
   int          src_wait = 0;
   int          sink_wait = 0;
   int          stall;
   int          items_queued = 0;
   int          items_taken = 0;
   int          commands_taken = 0;
   int          strobes_seen = 0;
   int          bad_seen = 0;
   int          errors = 0;
   int          quiet = 0;

   cyrillic_utf8_char_display_writer DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   function automatic logic [7:0] glyph_of(input int idx);
      return GLYPHS[(63 - idx) * 8 +: 8];
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at strobe %0d: %s", strobes_seen, what);
      errors++;
   endtask

   task automatic queue_write(input logic [7:0] code, input logic rs, input logic bad);
      if (cfg_narrow) begin
         strobes_due.push_back('{bus: {4'd0, code[7:4]}, rs: rs, last: 1'b0, bad: bad});
         strobes_due.push_back('{bus: {4'd0, code[3:0]}, rs: rs, last: 1'b1, bad: bad});
      end else begin
         strobes_due.push_back('{bus: code, rs: rs, last: 1'b1, bad: bad});
      end
   endtask

   task automatic transcode_item(input text_item_type it);
      logic [7:0] glyph;
      logic       bad_seq;
      glyph = cfg_replacement;
      bad_seq = 1'b1;
      if (it.action == ACT_CMD) begin
         queue_write(it.data, 1'b0, 1'b0);
      end else if (held == HELD_UPPER) begin
         if (it.data == cudw_pkg::UPPER_YO_BYTE) begin
            glyph = cudw_pkg::UPPER_YO_CODE;
            bad_seq = 1'b0;
         end else if (it.data >= cudw_pkg::UPPER_BASE && it.data <= cudw_pkg::UPPER_TOP) begin
            glyph = glyph_of(int'(it.data - cudw_pkg::UPPER_BASE));
            bad_seq = 1'b0;
         end
         held = HELD_NONE;
         queue_write(glyph, 1'b1, bad_seq);
      end else if (held == HELD_LOWER) begin
         if (it.data == cudw_pkg::LOWER_YO_BYTE) begin
            glyph = cudw_pkg::LOWER_YO_CODE;
            bad_seq = 1'b0;
         end else if (it.data >= cudw_pkg::LOWER_BASE && it.data <= cudw_pkg::LOWER_TOP) begin
            glyph = glyph_of(int'(cudw_pkg::LOWER_OFFSET) +
                             int'(it.data - cudw_pkg::LOWER_BASE));
            bad_seq = 1'b0;
         end
         held = HELD_NONE;
         queue_write(glyph, 1'b1, bad_seq);
      end else if (it.data == cudw_pkg::LEAD_UPPER) begin
         held = HELD_UPPER;
      end else if (it.data == cudw_pkg::LEAD_LOWER) begin
         held = HELD_LOWER;
      end else begin
         queue_write(it.data, 1'b1, 1'b0);
      end
      if (it.last)
         held = HELD_NONE;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         src_wait <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            transcode_item(on_bus);
            items_taken++;
            if (on_bus.action == ACT_CMD)
               commands_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (text_queue.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (src_wait < text_queue[0].gap) begin
               src_wait <= src_wait + 1;
               req_tvalid <= 1'b0;
            end else begin
               on_bus = text_queue.pop_front();
               req_tdata <= on_bus.data;
               req_tuser <= on_bus.action;
               req_tlast <= on_bus.last;
               req_tvalid <= 1'b1;
               src_wait <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_wait <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (strobes_due.size() == 0) begin
            report_mismatch("strobe with nothing expected");
         end else begin
            strobe_type exp_s;
            exp_s = strobes_due.pop_front();
            if (rsp_tdata !== exp_s.bus)
               report_mismatch($sformatf("bus_value %h, expected %h", rsp_tdata, exp_s.bus));
            if (rsp_tuser[0] !== exp_s.rs)
               report_mismatch($sformatf("register_select %b, expected %b",
                                         rsp_tuser[0], exp_s.rs));
            if (rsp_tlast !== exp_s.last)
               report_mismatch($sformatf("last_of_write %b, expected %b",
                                         rsp_tlast, exp_s.last));
            if (rsp_tuser[1] !== exp_s.bad)
               report_mismatch($sformatf("bad_sequence %b, expected %b",
                                         rsp_tuser[1], exp_s.bad));
            if (exp_s.bad)
               bad_seen++;
         end
         strobes_seen++;
         stall = sink_pace ? $urandom_range(0, 11) : 0;
         rsp_tready <= (stall == 0);
         sink_wait <= stall;
      end else if (!rsp_tready) begin
         if (sink_wait > 1)
            sink_wait <= sink_wait - 1;
         else
            rsp_tready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("cyrillic_utf8_char_display_writer regression: fail");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic add_item(input logic action, input logic [7:0] data, input logic last);
      text_queue.push_back('{action: action, data: data, last: last,
                             gap: src_pace ? $urandom_range(0, 11) : 0});
      items_queued++;
   endtask

   function automatic logic [7:0] valid_tail(input logic [7:0] lead);
      int r;
      if (lead == cudw_pkg::LEAD_UPPER) begin
         r = $urandom_range(0, 48);
         return (r == 48) ? cudw_pkg::UPPER_YO_BYTE : cudw_pkg::UPPER_BASE + 8'(r);
      end
      r = $urandom_range(0, 16);
      return (r == 16) ? cudw_pkg::LOWER_YO_BYTE : cudw_pkg::LOWER_BASE + 8'(r);
   endfunction

   function automatic logic rand_end();
      return ($urandom_range(0, 7) == 0);
   endfunction

   task automatic add_random_text(input int count);
      int         kind;
      logic [7:0] lead;
      int         start;
      start = items_queued;
      while (items_queued - start < count) begin
         kind = $urandom_range(0, 99);
         lead = $urandom_range(0, 1) ? cudw_pkg::LEAD_LOWER : cudw_pkg::LEAD_UPPER;
         if (kind < 50) begin
            add_item(ACT_TEXT, lead, 1'b0);
            add_item(ACT_TEXT, valid_tail(lead), rand_end());
         end else if (kind < 65) begin
            add_item(ACT_TEXT, 8'($urandom_range(0, 255)), rand_end());
         end else if (kind < 75) begin
            add_item(ACT_CMD, 8'($urandom_range(0, 255)), rand_end());
         end else if (kind < 85) begin
            add_item(ACT_TEXT, lead, 1'b0);
            add_item(ACT_TEXT, 8'($urandom_range(0, 255)), rand_end());
         end else if (kind < 93) begin
            add_item(ACT_TEXT, lead, 1'b1);
            add_item(ACT_TEXT, valid_tail(lead), rand_end());
         end else begin
            add_item(ACT_TEXT, lead, 1'b0);
            add_item(ACT_CMD, 8'($urandom_range(0, 255)), rand_end());
            add_item(ACT_TEXT, valid_tail(lead), rand_end());
         end
      end
   endtask

   task automatic csr_write(input logic idx, input logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == cudw_pkg::REG_NARROW_BUS)
         cfg_narrow = value[0];
      else
         cfg_replacement = value;
   endtask

   task automatic wait_drained();
      while (items_taken != items_queued || strobes_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic       narrow;
      logic [7:0] repl;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, mapped range edges, yo letters, broken pairs
      add_item(ACT_TEXT, 8'h00, 1'b0);
      add_item(ACT_TEXT, 8'hFF, 1'b1);
      add_item(ACT_CMD,  8'h00, 1'b0);
      add_item(ACT_CMD,  8'hFF, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LEAD_UPPER, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::UPPER_BASE, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LEAD_UPPER, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::UPPER_TOP, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LEAD_UPPER, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::UPPER_YO_BYTE, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LEAD_LOWER, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LOWER_BASE, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LEAD_LOWER, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LOWER_TOP, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LEAD_LOWER, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LOWER_YO_BYTE, 1'b1);
      add_item(ACT_TEXT, cudw_pkg::LEAD_UPPER, 1'b0);
      add_item(ACT_TEXT, 8'hC0, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LEAD_LOWER, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LEAD_UPPER, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LEAD_UPPER, 1'b1);
      add_item(ACT_TEXT, cudw_pkg::UPPER_BASE, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LEAD_LOWER, 1'b0);
      add_item(ACT_CMD,  8'h01, 1'b0);
      add_item(ACT_TEXT, cudw_pkg::LOWER_BASE, 1'b0);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         narrow = p[0];
         case (p)
            1: repl = 8'h00;
            2: repl = 8'hFF;
            3: repl = 8'h00;
            4: repl = 8'hFF;
            5: repl = cudw_pkg::REPLACEMENT_RESET;
            default: repl = 8'($urandom_range(0, 255));
         endcase
         csr_write(cudw_pkg::REG_NARROW_BUS, {7'd0, narrow});
         csr_write(cudw_pkg::REG_REPLACEMENT, repl);
         src_pace = (p % 3 != 2);
         sink_pace = (p % 4 != 3);
         add_random_text(ITEMS_PER_PHASE);
         wait_drained();
      end

      $display("covered %0d items (%0d commands), %0d strobes checked, %0d flagged bad",
               items_taken, commands_taken, strobes_seen, bad_seen);
      $display("both bus widths, replacement codes 0, 63, 255 and random, paced and unpaced");
      if (errors == 0)
         $display("cyrillic_utf8_char_display_writer regression: pass");
      else
         $display("cyrillic_utf8_char_display_writer regression: fail");
      $finish;
   end

endmodule

@@ cyrillic_utf8_char_display_writer.f @@
rtl/cudw_pkg.sv
rtl/cudw_front.sv
rtl/cudw_queue.sv
rtl/cudw_back.sv
rtl/cyrillic_utf8_char_display_writer.sv
tb/cyrillic_utf8_char_display_writer_tb.sv
